/* rtl/hsvc_pkg.sv */
// hsvc_pkg: shared types and constants for the hsv to rgb converter
// holds the colour transfer structs and the fixed point constants of the hue split
// no dependencies
package hsvc_pkg;

    // fraction bits of the hue/60 value
    localparam int FRAC_BITS = 24;

    // percentage ceiling
    localparam logic [6:0] PCT_MAX = 7'd100;

    // 359 degrees over hue codes 0..255, sixty degrees per sector
    localparam logic [16:0] HUE_SPAN  = 17'd359;
    localparam logic [15:0] HUE_DEN   = 16'd15300;
    localparam logic [15:0] HUE_HALF  = 16'd7650;
    localparam logic [34:0] HUE_RECIP = 35'((64'd1 << (2 * FRAC_BITS)) / 64'd15300);

    // sector codes of the hue split
    localparam logic [2:0] SEC_RED_YEL = 3'd0;
    localparam logic [2:0] SEC_YEL_GRN = 3'd1;
    localparam logic [2:0] SEC_GRN_CYN = 3'd2;
    localparam logic [2:0] SEC_CYN_BLU = 3'd3;
    localparam logic [2:0] SEC_BLU_MAG = 3'd4;
    localparam logic [2:0] SEC_MAG_RED = 3'd5;

    // input transfer
    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } hsv_t;

    // result transfer
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // sector and in-sector fraction from the hue pipeline
    typedef struct packed {
        logic                 valid;
        logic [2:0]           sector;
        logic [FRAC_BITS-1:0] frac;
    } hue_split_t;

endpackage

/* rtl/hsvc_hue_split.sv */
// hsvc_hue_split: three stage pipeline splitting the hue code into sector and fraction
// computes round(359 * hue * 2^24 / 15300) by reciprocal multiply and remainder fix-up
// depends on hsvc_pkg
module hsvc_hue_split
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_in,
    input  logic [7:0]             hue,
    output hsvc_pkg::hue_split_t   split
);

    logic [2:0]  vld_reg;
    logic [2:0]  vld_next;
    logic [16:0] x_reg;
    logic [16:0] x_next;
    logic [26:0] hs0_reg;
    logic [26:0] hs0_next;
    logic [26:0] hs_reg;
    logic [26:0] hs_next;

    logic [51:0] recip_prod;
    logic [42:0] hs0_scaled;
    logic [15:0] rem;
    logic [1:0]  corr;

    // stage one: hue in degrees times 255
    assign x_next = {9'd0, hue} * hsvc_pkg::HUE_SPAN;

    // stage two: estimate of hue/60, low by at most two units
    assign recip_prod = {35'd0, x_reg} * {17'd0, hsvc_pkg::HUE_RECIP};
    assign hs0_next   = recip_prod[50:24];

    // stage three: remainder is small, so its low bits suffice
    assign hs0_scaled = {16'd0, hs0_reg} * {27'd0, hsvc_pkg::HUE_DEN};
    assign rem        = hsvc_pkg::HUE_HALF - hs0_scaled[15:0];

    always_comb
    begin
        priority if (rem >= {hsvc_pkg::HUE_DEN[14:0], 1'b0})
        begin
            corr = 2'd2;
        end
        else if (rem >= hsvc_pkg::HUE_DEN)
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
    end

    assign hs_next  = hs0_reg + {25'd0, corr};
    assign vld_next = {vld_reg[1:0], valid_in};

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        hs0_reg <= hs0_next;
        hs_reg  <= hs_next;
    end

    assign split.valid  = vld_reg[2];
    assign split.sector = hs_reg[26:24];
    assign split.frac   = hs_reg[23:0];

endmodule

/* rtl/hsv_to_rgb_converter_unit.sv */
// hsv_to_rgb_converter_unit: top level of the hsv to rgb converter
// seven stage pipeline, hue split in hsvc_hue_split, channel terms here
// depends on hsvc_pkg and hsvc_hue_split
//
//  channel   signals           direction  transfer
//  input     start, busy, hsv  in         start high while busy low
//  result    done, rgb         out        done high for one cycle
//
// one colour is taken every cycle; busy is always low
// the result strobe rises together with the registered rgb of stage seven
// the stages hold the hue reciprocal multiply and the two divide-by-10000 passes
// reset clears the valid bits only; results in flight are dropped
// the receiver cannot stall, so nothing is held back
module hsv_to_rgb_converter_unit
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hsvc_pkg::hsv_t   hsv,
    output logic             done,
    output hsvc_pkg::rgb_t   rgb
);

    localparam int FB = hsvc_pkg::FRAC_BITS;

    // reciprocals rounded up, exact for the value ranges met here
    localparam logic [22:0] DIV_RECIP    = 23'(((64'd1 << 36) + 64'd9999) / 64'd10000);
    localparam logic [15:0] VV_RECIP     = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
    localparam logic [30:0] FRAC_HUNDRED = 31'(64'd100 << FB);
    localparam logic [24:0] FRAC_ONE     = 25'(64'd1 << FB);
    localparam logic [45:0] ROUND_QT     = 46'(64'd5000 << FB);
    localparam logic [21:0] ROUND_P      = 22'd5000;
    localparam logic [14:0] ROUND_V      = 15'd50;

    logic                 accept;
    hsvc_pkg::hue_split_t split;

    logic [6:0]  s_clamp;
    logic [6:0]  v_clamp;

    logic [6:0]  s1_s_reg;
    logic [14:0] s1_v255_reg;
    logic [14:0] s1_v255_next;

    logic [6:0]  s2_s_reg;
    logic [14:0] s2_v255_reg;
    logic [21:0] s2_yp_reg;
    logic [21:0] s2_yp_next;
    logic [14:0] s2_yv_reg;
    logic [14:0] s2_yv_next;

    logic [6:0]  s3_s_reg;
    logic [14:0] s3_v255_reg;
    logic [7:0]  s3_vv_reg;
    logic [7:0]  s3_pp_reg;
    logic [30:0] vv_prod;
    logic [44:0] pp_prod;

    logic [30:0] s4_wq_reg;
    logic [30:0] s4_wq_next;
    logic [30:0] s4_wt_reg;
    logic [30:0] s4_wt_next;
    logic [2:0]  s4_sector_reg;
    logic [14:0] s4_v255_reg;
    logic [7:0]  s4_vv_reg;
    logic [7:0]  s4_pp_reg;
    logic [30:0] sf_prod;
    logic [24:0] inv_frac;
    logic [31:0] sinv_prod;
    logic [31:0] wt_full;

    logic [21:0] s5_yq_reg;
    logic [21:0] s5_yt_reg;
    logic [2:0]  s5_sector_reg;
    logic [7:0]  s5_vv_reg;
    logic [7:0]  s5_pp_reg;
    logic [45:0] numq;
    logic [45:0] numt;

    logic [7:0]  s6_qq_reg;
    logic [7:0]  s6_tt_reg;
    logic [2:0]  s6_sector_reg;
    logic [7:0]  s6_vv_reg;
    logic [7:0]  s6_pp_reg;
    logic [44:0] qq_prod;
    logic [44:0] tt_prod;

    logic [2:0]     vld_reg;
    logic [2:0]     vld_next;
    hsvc_pkg::rgb_t rgb_reg;
    hsvc_pkg::rgb_t rgb_next;

    // every cycle is open for a transfer
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // hue path
    hsvc_hue_split u_hue_split
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (accept),
        .hue      (hsv.hue),
        .split    (split)
    );

    // stage one: clamp percentages, scale value by 255
    assign s_clamp = (hsv.saturation > {1'b0, hsvc_pkg::PCT_MAX}) ?
                     hsvc_pkg::PCT_MAX : hsv.saturation[6:0];
    assign v_clamp = (hsv.brightness > {1'b0, hsvc_pkg::PCT_MAX}) ?
                     hsvc_pkg::PCT_MAX : hsv.brightness[6:0];
    assign s1_v255_next = {v_clamp, 8'd0} - {8'd0, v_clamp};

    // stage two: numerators of v and p with rounding bias
    assign s2_yp_next = {7'd0, s1_v255_reg} * {15'd0, hsvc_pkg::PCT_MAX - s1_s_reg} + ROUND_P;
    assign s2_yv_next = s1_v255_reg + ROUND_V;

    // stage three: divide by 100 and by 10000
    assign vv_prod = {16'd0, s2_yv_reg} * {15'd0, VV_RECIP};
    assign pp_prod = {23'd0, s2_yp_reg} * {22'd0, DIV_RECIP};

    // stage four: q and t weights in 24 fraction bits
    assign sf_prod    = {24'd0, s3_s_reg} * {7'd0, split.frac};
    assign s4_wq_next = FRAC_HUNDRED - sf_prod;
    assign inv_frac   = FRAC_ONE - {1'b0, split.frac};
    assign sinv_prod  = {25'd0, s3_s_reg} * {7'd0, inv_frac};
    assign wt_full    = {1'b0, FRAC_HUNDRED} - sinv_prod;
    assign s4_wt_next = wt_full[30:0];

    // stage five: scale by 255v, drop fraction bits
    assign numq = {31'd0, s4_v255_reg} * {15'd0, s4_wq_reg} + ROUND_QT;
    assign numt = {31'd0, s4_v255_reg} * {15'd0, s4_wt_reg} + ROUND_QT;

    // stage six: divide by 10000
    assign qq_prod = {23'd0, s5_yq_reg} * {22'd0, DIV_RECIP};
    assign tt_prod = {23'd0, s5_yt_reg} * {22'd0, DIV_RECIP};

    // stage seven: route terms to channels by sector
    always_comb
    begin
        unique case (s6_sector_reg)
            hsvc_pkg::SEC_RED_YEL:
            begin
                rgb_next.red   = s6_vv_reg;
                rgb_next.green = s6_tt_reg;
                rgb_next.blue  = s6_pp_reg;
            end
            hsvc_pkg::SEC_YEL_GRN:
            begin
                rgb_next.red   = s6_qq_reg;
                rgb_next.green = s6_vv_reg;
                rgb_next.blue  = s6_pp_reg;
            end
            hsvc_pkg::SEC_GRN_CYN:
            begin
                rgb_next.red   = s6_pp_reg;
                rgb_next.green = s6_vv_reg;
                rgb_next.blue  = s6_tt_reg;
            end
            hsvc_pkg::SEC_CYN_BLU:
            begin
                rgb_next.red   = s6_pp_reg;
                rgb_next.green = s6_qq_reg;
                rgb_next.blue  = s6_vv_reg;
            end
            hsvc_pkg::SEC_BLU_MAG:
            begin
                rgb_next.red   = s6_tt_reg;
                rgb_next.green = s6_pp_reg;
                rgb_next.blue  = s6_vv_reg;
            end
            default:
            begin
                // magenta to red, also the top of the hue range
                rgb_next.red   = s6_vv_reg;
                rgb_next.green = s6_pp_reg;
                rgb_next.blue  = s6_qq_reg;
            end
        endcase
    end

    assign vld_next = {vld_reg[1:0], split.valid};

    // valid bits of stages four to seven
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done     <= vld_reg[2];
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        s1_s_reg      <= s_clamp;
        s1_v255_reg   <= s1_v255_next;

        s2_s_reg      <= s1_s_reg;
        s2_v255_reg   <= s1_v255_reg;
        s2_yp_reg     <= s2_yp_next;
        s2_yv_reg     <= s2_yv_next;

        s3_s_reg      <= s2_s_reg;
        s3_v255_reg   <= s2_v255_reg;
        s3_vv_reg     <= vv_prod[29:22];
        s3_pp_reg     <= pp_prod[43:36];

        s4_wq_reg     <= s4_wq_next;
        s4_wt_reg     <= s4_wt_next;
        s4_sector_reg <= split.sector;
        s4_v255_reg   <= s3_v255_reg;
        s4_vv_reg     <= s3_vv_reg;
        s4_pp_reg     <= s3_pp_reg;

        s5_yq_reg     <= numq[45:24];
        s5_yt_reg     <= numt[45:24];
        s5_sector_reg <= s4_sector_reg;
        s5_vv_reg     <= s4_vv_reg;
        s5_pp_reg     <= s4_pp_reg;

        s6_qq_reg     <= qq_prod[43:36];
        s6_tt_reg     <= tt_prod[43:36];
        s6_sector_reg <= s5_sector_reg;
        s6_vv_reg     <= s5_vv_reg;
        s6_pp_reg     <= s5_pp_reg;

        rgb_reg       <= rgb_next;
    end

    assign rgb = rgb_reg;

endmodule

/* rtl/hsvc_checker.sv */
// hsvc_checker: port level checks for the hsv to rgb converter
// watches the transfers on the top level ports, attached by bind below
// depends on hsvc_pkg and hsv_to_rgb_converter_unit
module hsvc_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input hsvc_pkg::hsv_t hsv,
    input logic           done,
    input hsvc_pkg::rgb_t rgb
);

    // the unit never refuses a transfer
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every input transfer yields a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("result missing after transfer");

    // no result without a matching input transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result without transfer");

    // zero saturation gives a grey
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && hsv.saturation == 8'd0) |->
        ##7 (rgb.red == rgb.green && rgb.green == rgb.blue))
        else $error("zero saturation not grey");

    // zero value gives black
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && hsv.brightness == 8'd0) |->
        ##7 (rgb.red == 8'd0 && rgb.green == 8'd0 && rgb.blue == 8'd0))
        else $error("zero value not black");

endmodule

bind hsv_to_rgb_converter_unit hsvc_checker u_hsvc_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .hsv   (hsv),
    .done  (done),
    .rgb   (rgb)
);
